// ===== sv/fpp_pkg.sv =====
package fpp_pkg;

  // Framing constants
  localparam logic [7:0] SYNC_FIRST   = 8'h5A;
  localparam logic [7:0] SYNC_SECOND  = 8'hA5;
  localparam logic [7:0] LENGTH_LIMIT = 8'd249;
  localparam logic [7:0] SHORT_LIMIT  = 8'd2;
  localparam logic [7:0] HEADER_SPAN  = 8'd6;

  // One classified transaction passed from the front to the back
  typedef struct packed {
    logic        is_end;
    logic [7:0]  data;
    logic [7:0]  pos;
    logic [7:0]  len;
    logic [15:0] chk;
    logic [15:0] sum;
  } item_t;

endpackage

// ===== sv/fpp_front.sv =====
module fpp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  output logic          wr_en,
  output fpp_pkg::item_t wr_item
);
  import fpp_pkg::*;

  typedef enum logic [1:0] {HUNT, GOT_SYNC, IN_FRAME} st_t;

  st_t         state, state_next;
  logic [7:0]  count, count_next;
  logic [7:0]  held_len, held_len_next;
  logic [15:0] sum, sum_next;
  logic [7:0]  chk_low, chk_low_next;
  logic [8:0]  idx_inc;

  assign idx_inc = {1'b0, count} + 9'd1;

  // Byte classification and frame tracking
  always_comb begin
    state_next    = state;
    count_next    = count;
    held_len_next = held_len;
    sum_next      = sum;
    chk_low_next  = chk_low;
    wr_en         = 1'b0;
    wr_item       = '0;
    if (in_valid) begin
      unique case (state)
        HUNT: begin
          if (in_byte == SYNC_FIRST) begin
            state_next = GOT_SYNC;
          end
        end
        GOT_SYNC: begin
          if (in_byte == SYNC_SECOND) begin
            state_next = IN_FRAME;
            count_next = '0;
            sum_next   = '0;
          end else begin
            state_next = HUNT;
          end
        end
        IN_FRAME: begin
          if (count == 8'd0) begin
            // length byte
            if (in_byte >= LENGTH_LIMIT) begin
              state_next    = HUNT;
              count_next    = '0;
              sum_next      = '0;
              held_len_next = '0;
              chk_low_next  = '0;
            end else if (in_byte < SHORT_LIMIT) begin
              // no room for a checksum: close the frame bad at once
              wr_en          = 1'b1;
              wr_item.is_end = 1'b1;
              wr_item.len    = in_byte;
              wr_item.sum    = {8'd0, in_byte};
              state_next     = HUNT;
              count_next     = '0;
              sum_next       = '0;
              held_len_next  = '0;
              chk_low_next   = '0;
            end else begin
              held_len_next = in_byte;
              sum_next      = {8'd0, in_byte};
              count_next    = 8'd1;
            end
          end else if (idx_inc < {1'b0, held_len}) begin
            // body byte, passed straight through
            sum_next     = sum + {8'd0, in_byte};
            count_next   = idx_inc[7:0];
            wr_en        = 1'b1;
            wr_item.data = in_byte;
            wr_item.pos  = count - 8'd1;
            wr_item.len  = held_len;
          end else if (idx_inc == {1'b0, held_len}) begin
            chk_low_next = in_byte;
            count_next   = idx_inc[7:0];
          end else begin
            // second checksum byte closes the frame
            wr_en          = 1'b1;
            wr_item.is_end = 1'b1;
            wr_item.len    = held_len;
            wr_item.chk    = {in_byte, chk_low};
            wr_item.sum    = sum;
            state_next     = HUNT;
            count_next     = '0;
            sum_next       = '0;
            held_len_next  = '0;
            chk_low_next   = '0;
          end
        end
        default: state_next = HUNT;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= HUNT;
      count    <= '0;
      held_len <= '0;
      sum      <= '0;
      chk_low  <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      held_len <= held_len_next;
      sum      <= sum_next;
      chk_low  <= chk_low_next;
    end
  end

endmodule

// ===== sv/fpp_queue.sv =====
module fpp_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  fpp_pkg::item_t wr_item,
  input  logic           rd_en,
  output fpp_pkg::item_t rd_item,
  output logic           q_empty,
  output logic           q_full
);
  import fpp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign q_empty = (fill == '0);
  assign q_full  = (fill == FULL_CNT);
  assign rd_item = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        fill <= fill + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/fpp_back.sv =====
module fpp_back (
  input  logic           clk,
  input  logic           rst,
  input  fpp_pkg::item_t rd_item,
  input  logic           q_empty,
  output logic           rd_en,
  input  logic           pop,
  output logic           out_valid,
  output logic [7:0]     body_byte,
  output logic [7:0]     body_position,
  output logic           frame_end,
  output logic           frame_good,
  output logic [7:0]     length_byte,
  output logic [7:0]     payload_length,
  output logic [15:0]    received_checksum
);
  import fpp_pkg::*;

  logic       good;
  logic [7:0] plen;

  // Load the output stage when it is free or being drained
  assign rd_en = !q_empty && (!out_valid || pop);

  // Verdict and payload length for a frame-end transaction
  always_comb begin
    good = rd_item.is_end && (~rd_item.sum == rd_item.chk);
    plen = '0;
    if (rd_item.is_end && rd_item.len > HEADER_SPAN) begin
      plen = rd_item.len - HEADER_SPAN;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_en) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (rd_en) begin
      body_byte         <= rd_item.data;
      body_position     <= rd_item.pos;
      frame_end         <= rd_item.is_end;
      frame_good        <= good;
      length_byte       <= rd_item.len;
      payload_length    <= plen;
      received_checksum <= rd_item.chk;
    end
  end

endmodule

// ===== sv/framed_packet_parser.sv =====
// Channel   Handshake      Fields
// input     push / full    rx_byte
// result    empty / pop    body_byte, body_position, frame_end, frame_good,
//                          length_byte, payload_length, received_checksum
//
// One byte is taken every cycle in which push is high and full is low, so the
// front parser accepts one byte per clock while full stays low.
// The front writes a result into the queue at the edge that accepts its byte;
// the output stage loads it from there once it is free or being popped.
// While pop is held low, up to QUEUE_DEPTH results wait in the queue plus one
// in the output stage before full rises.
// Synchronous reset returns the parser to hunting and empties the queue.
module framed_packet_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  body_byte,
  output logic [7:0]  body_position,
  output logic        frame_end,
  output logic        frame_good,
  output logic [7:0]  length_byte,
  output logic [7:0]  payload_length,
  output logic [15:0] received_checksum
);
  import fpp_pkg::*;

  logic  accept;
  logic  wr_en;
  item_t wr_item;
  logic  rd_en;
  item_t rd_item;
  logic  q_empty;
  logic  q_full;
  logic  out_valid;

  assign full   = q_full;
  assign empty  = !out_valid;
  assign accept = push && !q_full;

  // Front: sync hunt and frame classification
  fpp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(accept),
    .in_byte (rx_byte),
    .wr_en   (wr_en),
    .wr_item (wr_item)
  );

  // Decoupling queue
  fpp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_item(wr_item),
    .rd_en  (rd_en),
    .rd_item(rd_item),
    .q_empty(q_empty),
    .q_full (q_full)
  );

  // Back: checksum verdict and output stage
  fpp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .rd_item          (rd_item),
    .q_empty          (q_empty),
    .rd_en            (rd_en),
    .pop              (pop),
    .out_valid        (out_valid),
    .body_byte        (body_byte),
    .body_position    (body_position),
    .frame_end        (frame_end),
    .frame_good       (frame_good),
    .length_byte      (length_byte),
    .payload_length   (payload_length),
    .received_checksum(received_checksum)
  );

endmodule
